>>> hw/rtl/xsf_pkg.sv
// shared types and constants of the xor sprite framebuffer
package xsf_pkg;

    // default screen size
    localparam int XSF_DEF_WIDTH  = 64;
    localparam int XSF_DEF_HEIGHT = 32;

    // default depth of the queue between front and back
    localparam int XSF_DEF_QUEUE_DEPTH = 2;

    // coordinate widths sized for the largest screen (128 x 64)
    localparam int XSF_COL_W   = 7;
    localparam int XSF_ROW_W   = 6;
    localparam int XSF_COLOR_W = 15;

    typedef enum logic {
        REQ_DRAW = 1'b0,
        REQ_READ = 1'b1
    } t_xsf_req;

    // one classified request, as held in the queue
    typedef struct packed {
        t_xsf_req               req;
        logic [XSF_COL_W-1:0]   col;       // wrapped column (origin for draws)
        logic [XSF_ROW_W-1:0]   row;       // wrapped screen row
        logic [XSF_COLOR_W-1:0] color;     // palette colour for this row
        logic [7:0]             row_bits;
        logic                   clr_coll;  // draw that starts a sprite
        logic                   last_row;
    } t_xsf_item;

endpackage

>>> hw/rtl/xsf_front.sv
// front end: accepts requests, wraps coordinates and picks the palette colour
module xsf_front import xsf_pkg::*; #(
    parameter int SCREEN_WIDTH  = XSF_DEF_WIDTH,
    parameter int SCREEN_HEIGHT = XSF_DEF_HEIGHT
) (
    input  logic       i_start,
    input  logic       i_busy,
    input  logic       i_req_type,
    input  logic [7:0] i_x_pos,
    input  logic [7:0] i_y_pos,
    input  logic [3:0] i_row_index,
    input  logic [7:0] i_row_bits,
    input  logic       i_last_row,
    output logic       o_push,
    output t_xsf_item  o_item
);

    localparam int RSW = XSF_ROW_W + 1;

    localparam logic [XSF_COLOR_W-1:0] PALETTE [8] = '{
        15'h7c00, 15'h7de0, 15'h7fe0, 15'h03e0,
        15'h03ef, 15'h03ff, 15'h001f, 15'h7c1f
    };

    logic [XSF_COL_W-1:0] x_tab  [256];
    logic [XSF_ROW_W-1:0] y_tab  [256];
    logic [XSF_ROW_W-1:0] ri_tab [16];
    logic [RSW-1:0]       row_sum;
    logic [XSF_ROW_W-1:0] row_draw;
    logic [XSF_ROW_W-1:0] row_sel;
    t_xsf_req             req;

    // constant wrap tables, built at elaboration
    for (genvar g = 0; g < 256; g++) begin : g_xy_tab
        assign x_tab[g] = XSF_COL_W'(g % SCREEN_WIDTH);
        assign y_tab[g] = XSF_ROW_W'(g % SCREEN_HEIGHT);
    end
    for (genvar g = 0; g < 16; g++) begin : g_ri_tab
        assign ri_tab[g] = XSF_ROW_W'(g % SCREEN_HEIGHT);
    end

    assign req = t_xsf_req'(i_req_type);

    // both terms below the height, so one subtract wraps the sum
    always_comb begin
        row_sum = {1'b0, y_tab[i_y_pos]} + {1'b0, ri_tab[i_row_index]};
        if (row_sum >= RSW'(SCREEN_HEIGHT)) begin
            row_draw = XSF_ROW_W'(row_sum - RSW'(SCREEN_HEIGHT));
        end else begin
            row_draw = XSF_ROW_W'(row_sum);
        end
        row_sel = (req == REQ_READ) ? y_tab[i_y_pos] : row_draw;
    end

    assign o_push = i_start && !i_busy;

    always_comb begin
        o_item.req      = req;
        o_item.col      = x_tab[i_x_pos];
        o_item.row      = row_sel;
        o_item.color    = PALETTE[row_sel[4:2]];
        o_item.row_bits = i_row_bits;
        o_item.clr_coll = (req == REQ_DRAW) && (i_row_index == 4'd0);
        o_item.last_row = i_last_row;
    end

endmodule

>>> hw/rtl/xsf_queue.sv
// short fifo of classified requests between front and back
module xsf_queue import xsf_pkg::*; #(
    parameter int DEPTH = XSF_DEF_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_xsf_item i_item,
    input  logic      i_pop,
    output t_xsf_item o_item,
    output logic      o_empty,
    output logic      o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_xsf_item       r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> hw/rtl/xsf_back.sv
// back end: framebuffer memory, pixel read-modify-write and result register
module xsf_back import xsf_pkg::*; #(
    parameter int SCREEN_WIDTH  = XSF_DEF_WIDTH,
    parameter int SCREEN_HEIGHT = XSF_DEF_HEIGHT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_xsf_item              i_item,
    input  logic                   i_empty,
    output logic                   o_pop,
    output logic                   o_ready,
    output logic                   o_strobe,
    output logic                   o_collision,
    output logic [XSF_COLOR_W-1:0] o_pixel_color,
    output logic                   o_draw_done
);

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CSW   = XSF_COL_W + 1;

    typedef enum logic {
        S_CLEAR,
        S_RUN
    } t_state;

    logic [XSF_COLOR_W-1:0] mem [DEPTH];

    t_state                 r_state;
    logic [AW-1:0]          r_clr_addr;
    logic [2:0]             r_bit;
    logic                   r_coll;
    logic                   r_strobe;
    logic                   r_draw_done;
    logic [XSF_COLOR_W-1:0] r_pixel_color;

    // pixel stage
    logic                   r_op_vld;
    logic                   r_op_read;
    logic                   r_op_en;
    logic                   r_op_clr;
    logic                   r_op_last;
    logic                   r_op_last_row;
    logic [XSF_COLOR_W-1:0] r_op_color;
    logic [AW-1:0]          r_op_addr;
    logic [XSF_COLOR_W-1:0] r_mem_q;

    // write of the previous cycle, not yet seen by the read port
    logic                   r_fwd_vld;
    logic [AW-1:0]          r_fwd_addr;
    logic [XSF_COLOR_W-1:0] r_fwd_data;

    logic                   issue;
    logic                   is_read;
    logic [CSW-1:0]         col_sum;
    logic [CSW-1:0]         col_wrap;
    logic [AW-1:0]          rd_addr;
    logic [XSF_COLOR_W-1:0] old_pix;
    logic                   wr_px;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [XSF_COLOR_W-1:0] wr_data;
    logic                   n_coll;

    assign issue   = (r_state == S_RUN) && !i_empty;
    assign is_read = (i_item.req == REQ_READ);
    assign o_pop   = issue && (is_read || (r_bit == 3'd7));
    assign o_ready = (r_state == S_RUN);

    // column of the current pixel; a read always sits at offset zero
    always_comb begin
        col_sum = {1'b0, i_item.col} + CSW'(r_bit);
        if (col_sum >= CSW'(SCREEN_WIDTH)) begin
            col_wrap = col_sum - CSW'(SCREEN_WIDTH);
        end else begin
            col_wrap = col_sum;
        end
        rd_addr = AW'(i_item.row) * AW'(SCREEN_WIDTH) + AW'(col_wrap);
    end

    always_comb begin
        old_pix = (r_fwd_vld && (r_fwd_addr == r_op_addr)) ? r_fwd_data : r_mem_q;
        wr_px   = r_op_vld && !r_op_read && r_op_en;
        wr_en   = (r_state == S_CLEAR) || wr_px;
        wr_addr = (r_state == S_CLEAR) ? r_clr_addr : r_op_addr;
        wr_data = (r_state == S_CLEAR) ? '0 : (old_pix ^ r_op_color);
        if (r_op_vld && !r_op_read) begin
            n_coll = (r_op_clr ? 1'b0 : r_coll) | (r_op_en && (old_pix != '0));
        end else begin
            n_coll = r_coll;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_mem_q <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_bit      <= '0;
            r_op_vld   <= 1'b0;
            r_fwd_vld  <= 1'b0;
            r_coll     <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_RUN;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                S_RUN: begin
                    r_state <= S_RUN;
                end
            endcase
            if (issue && !is_read) begin
                r_bit <= r_bit + 1'b1;
            end
            r_op_vld  <= issue;
            r_fwd_vld <= wr_px;
            r_coll    <= n_coll;
            r_strobe  <= r_op_vld && r_op_last;
        end
        r_pixel_color <= r_op_read ? old_pix : '0;
        r_draw_done   <= !r_op_read && r_op_last_row;
    end

    always_ff @(posedge i_clk) begin
        r_op_read     <= is_read;
        r_op_en       <= i_item.row_bits[~r_bit];
        r_op_clr      <= i_item.clr_coll && (r_bit == 3'd0);
        r_op_last     <= is_read || (r_bit == 3'd7);
        r_op_last_row <= i_item.last_row;
        r_op_color    <= i_item.color;
        r_op_addr     <= rd_addr;
        r_fwd_addr    <= r_op_addr;
        r_fwd_data    <= wr_data;
    end

    assign o_strobe      = r_strobe;
    assign o_collision   = r_coll;
    assign o_pixel_color = r_pixel_color;
    assign o_draw_done   = r_draw_done;

endmodule

>>> hw/rtl/xor_sprite_framebuffer.sv
// top level of the xor sprite framebuffer
//
// A SCREEN_WIDTH x SCREEN_HEIGHT framebuffer of 15-bit colour words. A draw
// transaction XORs one 8-pixel sprite row (bit 7 leftmost) into screen row
// (y + row_index) at columns x .. x+7, both wrapped, using the palette colour
// of that screen row (row mod 32, divided by 4); a lit pixel under a set bit
// raises the collision flag, which row_index 0 clears first. A read
// transaction returns one pixel. A transaction is taken when start is high
// and busy is low. Each transaction gives exactly one result, shown for one
// cycle with o_strobe; the receiver cannot stall, so results must be taken as
// they come. A draw occupies the back end one pixel per cycle, through the
// separate read and write ports of the framebuffer memory. The result strobe
// follows the back end's last pixel of a transaction through the pixel stage
// register and then the result register. A two-entry queue lets start be
// accepted while the back end is still drawing; busy rises when it is full.
// After reset the framebuffer is cleared one word per cycle, with busy held
// high.
module xor_sprite_framebuffer import xsf_pkg::*; #(
    parameter int SCREEN_WIDTH  = XSF_DEF_WIDTH,
    parameter int SCREEN_HEIGHT = XSF_DEF_HEIGHT,
    parameter int QUEUE_DEPTH   = XSF_DEF_QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_req_type,
    input  logic [7:0]             i_x_pos,
    input  logic [7:0]             i_y_pos,
    input  logic [3:0]             i_row_index,
    input  logic [7:0]             i_row_bits,
    input  logic                   i_last_row,
    output logic                   o_strobe,
    output logic                   o_collision,
    output logic [XSF_COLOR_W-1:0] o_pixel_color,
    output logic                   o_draw_done
);

    t_xsf_item fe_item;
    t_xsf_item q_item;
    logic      fe_push;
    logic      q_empty;
    logic      q_full;
    logic      be_pop;
    logic      be_ready;

    // busy while the clearing pass runs or the queue has no room
    assign busy = !be_ready || q_full;

    // front: coordinate wrap and palette choice, no storage
    xsf_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_start     (start),
        .i_busy      (busy),
        .i_req_type  (i_req_type),
        .i_x_pos     (i_x_pos),
        .i_y_pos     (i_y_pos),
        .i_row_index (i_row_index),
        .i_row_bits  (i_row_bits),
        .i_last_row  (i_last_row),
        .o_push      (fe_push),
        .o_item      (fe_item)
    );

    // decoupling queue
    xsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_item  (fe_item),
        .i_pop   (be_pop),
        .o_item  (q_item),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // back: memory, read-modify-write pipeline, collision flag, result register
    xsf_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (q_item),
        .i_empty       (q_empty),
        .o_pop         (be_pop),
        .o_ready       (be_ready),
        .o_strobe      (o_strobe),
        .o_collision   (o_collision),
        .o_pixel_color (o_pixel_color),
        .o_draw_done   (o_draw_done)
    );

endmodule

>>> hw/rtl/xsf_checker.sv
// port-level checks of the xor sprite framebuffer, bound to the top level
module xsf_checker import xsf_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   busy,
    input logic                   o_strobe,
    input logic                   o_collision,
    input logic [XSF_COLOR_W-1:0] o_pixel_color,
    input logic                   o_draw_done
);

    // the clearing pass holds busy in the first cycle out of reset
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> busy)
        else $error("busy low straight after reset");

    // a draw result carries no colour
    a_draw_no_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_draw_done) |-> (o_pixel_color == '0))
        else $error("draw result with nonzero colour");

    // back-to-back results can only end in a read, which leaves the flag alone
    a_read_keeps_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(o_strobe)) |-> (o_collision == $past(o_collision)))
        else $error("collision flag changed by a read");

endmodule

bind xor_sprite_framebuffer xsf_checker u_xsf_checker (.*);
